/* src/prap_pkg.sv */
// Shared types, constants and tables for the point rotation pipeline.
`timescale 1ns / 1ps

package prap_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries     = 32;
  localparam longint      KinfQ30         = 64'sd652032874;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned CordW  = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [CordW-1:0]  cord_t;

  // Quadrant folded out of the angle before the rotation.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Everything that rides alongside the rotation stages.
  typedef struct packed {
    diff_t  dx;
    diff_t  dy;
    coord_t pivot_x;
    coord_t pivot_y;
    quad_e  quad;
  } carry_t;

  // One beat inside the rotation pipeline: Q2.30 vector, angle left to turn.
  typedef struct packed {
    cord_t  x;
    cord_t  y;
    cord_t  z;
    carry_t carry;
  } rot_t;

  // Arctangent of 2^-idx in units of 2^32 per full turn.
  function automatic cord_t atan_lut(input int unsigned idx);
    cord_t val;
    case (idx)
      0:  val = 32'sd536870912;
      1:  val = 32'sd316933406;
      2:  val = 32'sd167458907;
      3:  val = 32'sd85004756;
      4:  val = 32'sd42667331;
      5:  val = 32'sd21354465;
      6:  val = 32'sd10679838;
      7:  val = 32'sd5340245;
      8:  val = 32'sd2670163;
      9:  val = 32'sd1335087;
      10: val = 32'sd667544;
      11: val = 32'sd333772;
      12: val = 32'sd166886;
      13: val = 32'sd83443;
      14: val = 32'sd41722;
      15: val = 32'sd20861;
      16: val = 32'sd10430;
      17: val = 32'sd5215;
      18: val = 32'sd2608;
      19: val = 32'sd1304;
      20: val = 32'sd652;
      21: val = 32'sd326;
      22: val = 32'sd163;
      23: val = 32'sd81;
      24: val = 32'sd41;
      25: val = 32'sd20;
      26: val = 32'sd10;
      27: val = 32'sd5;
      28: val = 32'sd3;
      29: val = 32'sd1;
      30: val = 32'sd1;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

  // Starting x of the rotation: inverse gain with a small correction term.
  function automatic cord_t gain_start(input int unsigned stages);
    logic [63:0] kinf;
    logic [63:0] corr;
    logic [63:0] k;
    kinf = 64'(KinfQ30);
    corr = (kinf * 64'd2) / 64'd3;
    k    = kinf + (corr >> (2 * stages));
    return cord_t'(k[CordW-1:0]);
  endfunction

endpackage

/* src/prap_prep.sv */
// Input stage: pivot differences, quadrant fold and rotation start vector.
`timescale 1ns / 1ps

module prap_prep #(
  parameter int unsigned CORDIC_STAGES = prap_pkg::CordicStagesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [prap_pkg::CoordW-1:0]   point_x_i,
  input  logic signed [prap_pkg::CoordW-1:0]   point_y_i,
  input  logic signed [prap_pkg::CoordW-1:0]   pivot_x_i,
  input  logic signed [prap_pkg::CoordW-1:0]   pivot_y_i,
  input  logic        [prap_pkg::AngleW-1:0]   turn_angle_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output prap_pkg::rot_t                       out_data_o
);
  import prap_pkg::*;

  logic [AngleW-1:0] ang_bias;
  logic [AngleW-1:0] resid;
  rot_t              data_d;
  rot_t              data_q;
  logic              valid_q;

  // The quadrant is the angle rounded to the nearest quarter turn.
  assign ang_bias = turn_angle_i + AngleW'(8192);
  assign resid    = turn_angle_i - {ang_bias[AngleW-1:AngleW-2], 14'd0};

  always_comb begin
    data_d               = '0;
    data_d.x             = gain_start(CORDIC_STAGES);
    data_d.y             = '0;
    data_d.z             = cord_t'({resid, 16'd0});
    data_d.carry.dx      = diff_t'(point_x_i) - diff_t'(pivot_x_i);
    data_d.carry.dy      = diff_t'(point_y_i) - diff_t'(pivot_y_i);
    data_d.carry.pivot_x = pivot_x_i;
    data_d.carry.pivot_y = pivot_y_i;
    data_d.carry.quad    = quad_e'(ang_bias[AngleW-1:AngleW-2]);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* src/prap_cordic.sv */
// Rotation-mode CORDIC, one registered micro-rotation per stage.
`timescale 1ns / 1ps

module prap_cordic #(
  parameter int unsigned CORDIC_STAGES = prap_pkg::CordicStagesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prap_pkg::rot_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output prap_pkg::rot_t out_data_o
);
  import prap_pkg::*;

  localparam int unsigned NumStages =
    (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

  rot_t                 stage_q [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;

  assign ready[NumStages] = out_ready_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    rot_t  src;
    logic  src_valid;
    rot_t  nxt;
    cord_t xs;
    cord_t ys;

    if (k == 0) begin : g_first
      assign src       = in_data_i;
      assign src_valid = in_valid_i;
    end else begin : g_rest
      assign src       = stage_q[k-1];
      assign src_valid = valid_q[k-1];
    end

    assign ready[k] = !valid_q[k] || ready[k+1];

    // Both updates use the vector from before this micro-rotation.
    always_comb begin
      xs  = $signed(src.x) >>> k;
      ys  = $signed(src.y) >>> k;
      nxt = src;
      if (!src.z[CordW-1]) begin
        nxt.x = src.x - ys;
        nxt.y = src.y + xs;
        nxt.z = src.z - atan_lut(k);
      end else begin
        nxt.x = src.x + ys;
        nxt.y = src.y - xs;
        nxt.z = src.z + atan_lut(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && src_valid) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = stage_q[NumStages-1];

endmodule

/* src/prap_mult.sv */
// Back end: quadrant unfold, split products, rounding, pivot add and saturation.
`timescale 1ns / 1ps

module prap_mult (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  prap_pkg::rot_t                     in_data_i,
  output logic signed [prap_pkg::CoordW-1:0] rotated_x_o,
  output logic signed [prap_pkg::CoordW-1:0] rotated_y_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import prap_pkg::*;

  localparam int unsigned HiW   = DiffW + 16;
  localparam int unsigned LoW   = DiffW + 17;
  localparam int unsigned SumW  = 2 * DiffW;
  localparam int unsigned RndW  = SumW - 30;
  localparam int unsigned TotW  = RndW + 1;

  typedef logic signed [HiW-1:0]  hi_t;
  typedef logic signed [LoW-1:0]  lo_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [RndW-1:0] rnd_t;
  typedef logic signed [TotW-1:0] tot_t;

  typedef struct packed {
    coord_t pivot_x;
    coord_t pivot_y;
  } piv_t;

  logic [2:0] valid_q;
  logic [3:0] ready;

  // Stage 1: sine and cosine, then partial products against 16-bit halves.
  cord_t             cos_v;
  cord_t             sin_v;
  logic signed [15:0] cos_hi;
  logic signed [15:0] sin_hi;
  logic signed [16:0] cos_lo;
  logic signed [16:0] sin_lo;
  hi_t  xc_hi_d, ys_hi_d, xs_hi_d, yc_hi_d;
  lo_t  xc_lo_d, ys_lo_d, xs_lo_d, yc_lo_d;
  hi_t  xc_hi_q, ys_hi_q, xs_hi_q, yc_hi_q;
  lo_t  xc_lo_q, ys_lo_q, xs_lo_q, yc_lo_q;
  piv_t piv1_q;

  // Stage 2: full sums with the rounding half added.
  sum_t rx_sum_d, ry_sum_d;
  sum_t rx_sum_q, ry_sum_q;
  piv_t piv2_q;

  // Stage 3: scale back, add the pivot, saturate.
  rnd_t   rx_rnd, ry_rnd;
  tot_t   rx_tot, ry_tot;
  coord_t rx_d, ry_d;
  coord_t rx_q, ry_q;

  assign ready[3] = out_ready_i;
  assign ready[2] = !valid_q[2] || ready[3];
  assign ready[1] = !valid_q[1] || ready[2];
  assign ready[0] = !valid_q[0] || ready[1];

  always_comb begin
    case (in_data_i.carry.quad)
      QUAD_1: begin
        cos_v = -in_data_i.y;
        sin_v = in_data_i.x;
      end
      QUAD_2: begin
        cos_v = -in_data_i.x;
        sin_v = -in_data_i.y;
      end
      QUAD_3: begin
        cos_v = in_data_i.y;
        sin_v = -in_data_i.x;
      end
      default: begin
        cos_v = in_data_i.x;
        sin_v = in_data_i.y;
      end
    endcase
  end

  assign cos_hi = cos_v[CordW-1:16];
  assign sin_hi = sin_v[CordW-1:16];
  assign cos_lo = $signed({1'b0, cos_v[15:0]});
  assign sin_lo = $signed({1'b0, sin_v[15:0]});

  assign xc_hi_d = hi_t'(in_data_i.carry.dx) * hi_t'(cos_hi);
  assign ys_hi_d = hi_t'(in_data_i.carry.dy) * hi_t'(sin_hi);
  assign xs_hi_d = hi_t'(in_data_i.carry.dx) * hi_t'(sin_hi);
  assign yc_hi_d = hi_t'(in_data_i.carry.dy) * hi_t'(cos_hi);
  assign xc_lo_d = lo_t'(in_data_i.carry.dx) * lo_t'(cos_lo);
  assign ys_lo_d = lo_t'(in_data_i.carry.dy) * lo_t'(sin_lo);
  assign xs_lo_d = lo_t'(in_data_i.carry.dx) * lo_t'(sin_lo);
  assign yc_lo_d = lo_t'(in_data_i.carry.dy) * lo_t'(cos_lo);

  assign rx_sum_d = (sum_t'(xc_hi_q) <<< 16) + sum_t'(xc_lo_q)
                  - (sum_t'(ys_hi_q) <<< 16) - sum_t'(ys_lo_q)
                  + (sum_t'(1) <<< 29);
  assign ry_sum_d = (sum_t'(xs_hi_q) <<< 16) + sum_t'(xs_lo_q)
                  + (sum_t'(yc_hi_q) <<< 16) + sum_t'(yc_lo_q)
                  + (sum_t'(1) <<< 29);

  assign rx_rnd = rx_sum_q[SumW-1:30];
  assign ry_rnd = ry_sum_q[SumW-1:30];
  assign rx_tot = tot_t'(rx_rnd) + tot_t'(piv2_q.pivot_x);
  assign ry_tot = tot_t'(ry_rnd) + tot_t'(piv2_q.pivot_y);

  // In range when every bit above the result width matches its sign bit.
  always_comb begin
    if (rx_tot[TotW-1:CoordW-1] == '0 || rx_tot[TotW-1:CoordW-1] == '1) begin
      rx_d = rx_tot[CoordW-1:0];
    end else begin
      rx_d = rx_tot[TotW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    if (ry_tot[TotW-1:CoordW-1] == '0 || ry_tot[TotW-1:CoordW-1] == '1) begin
      ry_d = ry_tot[CoordW-1:0];
    end else begin
      ry_d = ry_tot[TotW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      if (ready[1]) begin
        valid_q[1] <= valid_q[0];
      end
      if (ready[2]) begin
        valid_q[2] <= valid_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) begin
      xc_hi_q        <= xc_hi_d;
      ys_hi_q        <= ys_hi_d;
      xs_hi_q        <= xs_hi_d;
      yc_hi_q        <= yc_hi_d;
      xc_lo_q        <= xc_lo_d;
      ys_lo_q        <= ys_lo_d;
      xs_lo_q        <= xs_lo_d;
      yc_lo_q        <= yc_lo_d;
      piv1_q.pivot_x <= in_data_i.carry.pivot_x;
      piv1_q.pivot_y <= in_data_i.carry.pivot_y;
    end
    if (ready[1] && valid_q[0]) begin
      rx_sum_q <= rx_sum_d;
      ry_sum_q <= ry_sum_d;
      piv2_q   <= piv1_q;
    end
    if (ready[2] && valid_q[1]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[2];
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;

endmodule

/* src/point_rotate_about_pivot.sv */
// Top level of the point rotation pipeline.
`timescale 1ns / 1ps

// Rotates a signed Q16.16 point counter-clockwise about a pivot by a 16-bit
// binary angle (65536 is one full turn) and returns the saturated Q16.16
// result. The block is a fully pipelined stream: it takes one beat per clock
// while the output side is not stalled and returns the results in order.
// Each beat passes through one input stage, one register per CORDIC
// micro-rotation, and three back-end stages (split multiply, sum and round,
// pivot add and saturate). Every stage holds its own valid bit and only
// stalls when the stage after it is full and blocked, so empty slots are
// squeezed out and the input keeps accepting beats while a finished result
// waits on the output. There is no configuration and no state beyond the
// pipeline itself.

module point_rotate_about_pivot #(
  parameter int unsigned CORDIC_STAGES = prap_pkg::CordicStagesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [prap_pkg::CoordW-1:0] point_x_i,
  input  logic signed [prap_pkg::CoordW-1:0] point_y_i,
  input  logic signed [prap_pkg::CoordW-1:0] pivot_x_i,
  input  logic signed [prap_pkg::CoordW-1:0] pivot_y_i,
  input  logic        [prap_pkg::AngleW-1:0] turn_angle_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic signed [prap_pkg::CoordW-1:0] rotated_x_o,
  output logic signed [prap_pkg::CoordW-1:0] rotated_y_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import prap_pkg::*;

  // Prep to CORDIC.
  rot_t prep_data;
  logic prep_valid;
  logic prep_ready;

  // CORDIC to back end.
  rot_t rot_data;
  logic rot_valid;
  logic rot_ready;

  // The prep stage removes the pivot and folds the angle into one quadrant
  // so the CORDIC only ever has to turn through at most an eighth of a turn.
  prap_prep #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .pivot_x_i   (pivot_x_i),
    .pivot_y_i   (pivot_y_i),
    .turn_angle_i(turn_angle_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  // The CORDIC starts from the inverse gain, so it ends on cosine and sine
  // directly; the differences and pivot ride along unchanged.
  prap_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (prep_valid),
    .in_ready_o (prep_ready),
    .in_data_i  (prep_data),
    .out_valid_o(rot_valid),
    .out_ready_i(rot_ready),
    .out_data_o (rot_data)
  );

  // The back end restores the quadrant, applies the rotation to the 33-bit
  // differences with split multipliers, rounds to Q16.16 and adds the pivot.
  prap_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rot_valid),
    .in_ready_o (rot_ready),
    .in_data_i  (rot_data),
    .rotated_x_o(rotated_x_o),
    .rotated_y_o(rotated_y_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule

/* src/prap_checker.sv */
// Port-level checks for the point rotation pipeline, bound to the top level.
`timescale 1ns / 1ps

module prap_checker #(
  parameter int unsigned CORDIC_STAGES = prap_pkg::CordicStagesDef
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic signed [prap_pkg::CoordW-1:0] rotated_x_o,
  input logic signed [prap_pkg::CoordW-1:0] rotated_y_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i
);
  import prap_pkg::*;

  localparam int unsigned NumStages =
    (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;
  localparam int unsigned Depth = NumStages + 4;
  localparam int unsigned CntW  = $clog2(Depth + 2);

  logic            in_beat;
  logic            out_beat;
  logic [CntW-1:0] cnt_d;
  logic [CntW-1:0] cnt_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;
  assign cnt_d    = cnt_q + CntW'(in_beat) - CntW'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The pipeline never holds more beats than it has stages.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("more beats in flight than pipeline stages");

  // A result only appears for a beat that went in and has not come out.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result shown with no beat in flight");

  // With the output slot empty, the input side cannot be blocked.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output slot is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rotated_x_o) && $stable(rotated_y_o))
    else $error("result changed while stalled");

endmodule

bind point_rotate_about_pivot prap_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_prap_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .rotated_x_o(rotated_x_o),
  .rotated_y_o(rotated_y_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i)
);
